/* rtl/assert_macros.svh */
// Assertion macros shared by the allocator RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_RST(name, clk, rst_n, prop)
`define ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

/* rtl/bba_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the bitmap block allocator.
// Used by every module of the block but bba_map; depends on nothing.
package bba_pkg;

    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 16;
    localparam int COUNT_W    = 7;
    localparam int IDX_OUT_W  = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int STEP_W     = 5;
    localparam int OUT_DATA_W = 40;

    localparam logic [STEP_W-1:0] DIV_LAST = 5'd31;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

    localparam logic KIND_FREE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOT_USED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SCAN  = 2'd1,
        S_DIV   = 2'd2,
        S_CHECK = 2'd3
    } t_state;

    typedef enum logic [2:0] {
        OP_HOLD      = 3'd0,
        OP_LOAD_BASE = 3'd1,
        OP_OFFSET    = 3'd2,
        OP_ADD_SIZE  = 3'd3,
        OP_DIV       = 3'd4,
        OP_CMP_N     = 3'd5
    } t_op;

    typedef struct packed {
        t_op     op;
        logic    map_set;
        logic    map_clr;
        logic    out_load;
        logic    use_q;
        t_status out_status;
    } t_ctrl;

    typedef struct packed {
        logic scan_end;
        logic div_last;
        logic q_ge_n;
    } t_flags;

endpackage

/* rtl/bba_map.sv */
`timescale 1ns / 1ps
// Used-bit map of the pool with one read and one set or clear per cycle.
// Depends only on the shared assertion macros.
`include "assert_macros.svh"
module bba_map #(
    parameter int BLOCKS = 64,
    localparam int IW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1,
    localparam int MW = 2 ** IW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [IW-1:0] i_idx,
    input  logic          i_set,
    input  logic          i_clr,
    output logic          o_used
);

    logic [MW-1:0] r_map;
    logic [MW-1:0] n_map;

    always_comb begin
        n_map = r_map;
        if (i_set) begin
            n_map[i_idx] = 1'b1;
        end else if (i_clr) begin
            n_map[i_idx] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= '0;
        end else begin
            r_map <= n_map;
        end
    end

    assign o_used = r_map[i_idx];

    `ASSERT_RST(a_set_takes, i_clk, i_rst_n, i_set |=> r_map[$past(i_idx)])
    `ASSERT_RST(a_clr_takes, i_clk, i_rst_n, i_clr |=> !r_map[$past(i_idx)])

endmodule

/* rtl/bba_dpath.sv */
`timescale 1ns / 1ps
// Configuration registers and the shared adder for the free offset, address
// stepping, the serial divider and the range compare. Depends on bba_pkg.
`include "assert_macros.svh"
module bba_dpath #(
    parameter int BLOCKS = 64,
    localparam int IW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1,
    localparam int CW = $clog2(BLOCKS + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bba_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [bba_pkg::ADDR_W-1:0]      i_free_addr,
    input  bba_pkg::t_ctrl                  i_ctrl,
    output bba_pkg::t_flags                 o_flags,
    output logic [IW-1:0]                   o_map_idx,
    output logic [bba_pkg::ADDR_W-1:0]      o_res_addr,
    output logic [bba_pkg::IDX_OUT_W-1:0]   o_res_idx
);

    localparam logic [31:0] BLOCKS_W = 32'(BLOCKS);

    logic [bba_pkg::ADDR_W-1:0]  r_base;
    logic [bba_pkg::SIZE_W-1:0]  r_size;
    logic [bba_pkg::COUNT_W-1:0] r_count;
    logic [bba_pkg::ADDR_W-1:0]  r_acc;
    logic [bba_pkg::SIZE_W-1:0]  r_rem;
    logic [bba_pkg::STEP_W-1:0]  r_step;
    logic [CW-1:0]               r_idx;

    logic [bba_pkg::SIZE_W-1:0]  w_size;
    logic [31:0]                 w_count32;
    logic [CW-1:0]               w_n;
    logic [31:0]                 w_a;
    logic [31:0]                 w_b;
    logic                        w_cin;
    logic [32:0]                 w_sum;
    logic                        w_carry;
    logic [31:0]                 w_idx32;

    assign w_size    = (r_size == '0) ? 16'd1 : r_size;
    assign w_count32 = {25'd0, r_count};
    assign w_n       = (w_count32 > BLOCKS_W) ? BLOCKS_W[CW-1:0] : w_count32[CW-1:0];

    always_comb begin
        w_a   = '0;
        w_b   = '0;
        w_cin = 1'b0;
        unique case (i_ctrl.op)
            bba_pkg::OP_OFFSET: begin
                w_a   = i_free_addr;
                w_b   = ~r_base;
                w_cin = 1'b1;
            end
            bba_pkg::OP_ADD_SIZE: begin
                w_a = r_acc;
                w_b = {16'd0, w_size};
            end
            bba_pkg::OP_DIV: begin
                w_a   = {15'd0, r_rem, r_acc[31]};
                w_b   = ~{16'd0, w_size};
                w_cin = 1'b1;
            end
            bba_pkg::OP_CMP_N: begin
                w_a   = r_acc;
                w_b   = ~{{(32 - CW){1'b0}}, w_n};
                w_cin = 1'b1;
            end
            default: begin
                w_a   = '0;
                w_b   = '0;
                w_cin = 1'b0;
            end
        endcase
    end

    assign w_sum   = {1'b0, w_a} + {1'b0, w_b} + {32'd0, w_cin};
    assign w_carry = w_sum[32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_size  <= 16'd1;
            r_count <= 7'd64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bba_pkg::CFG_BASE:  r_base  <= i_cfg_data;
                bba_pkg::CFG_SIZE:  r_size  <= i_cfg_data[bba_pkg::SIZE_W-1:0];
                bba_pkg::CFG_COUNT: r_count <= i_cfg_data[bba_pkg::COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_step <= '0;
        end else begin
            unique case (i_ctrl.op)
                bba_pkg::OP_LOAD_BASE: r_idx  <= '0;
                bba_pkg::OP_OFFSET:    r_step <= '0;
                bba_pkg::OP_ADD_SIZE:  r_idx  <= r_idx + 1'b1;
                bba_pkg::OP_DIV:       r_step <= r_step + 1'b1;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.op)
            bba_pkg::OP_LOAD_BASE: r_acc <= r_base;
            bba_pkg::OP_OFFSET: begin
                r_acc <= w_sum[31:0];
                r_rem <= '0;
            end
            bba_pkg::OP_ADD_SIZE:  r_acc <= w_sum[31:0];
            bba_pkg::OP_DIV: begin
                r_acc <= {r_acc[30:0], w_carry};
                r_rem <= w_carry ? w_sum[15:0] : w_a[15:0];
            end
            default: begin
            end
        endcase
    end

    assign o_flags.scan_end = (r_idx >= w_n);
    assign o_flags.div_last = (r_step == bba_pkg::DIV_LAST);
    assign o_flags.q_ge_n   = w_carry;

    assign o_map_idx = i_ctrl.use_q ? r_acc[IW-1:0] : r_idx[IW-1:0];
    assign w_idx32   = {{(32 - CW){1'b0}}, r_idx};

    always_comb begin
        o_res_addr = '0;
        o_res_idx  = '0;
        if (i_ctrl.use_q) begin
            if (i_ctrl.out_status != bba_pkg::ST_RANGE) begin
                o_res_idx = r_acc[bba_pkg::IDX_OUT_W-1:0];
            end
        end else if (i_ctrl.out_status == bba_pkg::ST_OK) begin
            o_res_addr = r_acc;
            o_res_idx  = w_idx32[bba_pkg::IDX_OUT_W-1:0];
        end
    end

    `ASSERT_RST(a_rem_below_size, i_clk, i_rst_n,
        (i_ctrl.op == bba_pkg::OP_DIV) |=> (r_rem < w_size))

endmodule

/* rtl/bba_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer of the allocator: scan for allocate, divide and check for free.
// Depends on bba_pkg for the state, operation and control types.
`include "assert_macros.svh"
module bba_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_kind,
    input  logic            i_out_free,
    input  logic            i_bit_used,
    input  bba_pkg::t_flags i_flags,
    output logic            o_in_ready,
    output bba_pkg::t_ctrl  o_ctrl
);

    bba_pkg::t_state r_state;
    bba_pkg::t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bba_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_kind == bba_pkg::KIND_FREE) ? bba_pkg::S_DIV
                                                                : bba_pkg::S_SCAN;
                end
            end
            bba_pkg::S_SCAN: begin
                if ((i_flags.scan_end || !i_bit_used) && i_out_free) begin
                    n_state = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_DIV: begin
                if (i_flags.div_last) begin
                    n_state = bba_pkg::S_CHECK;
                end
            end
            bba_pkg::S_CHECK: begin
                if (i_out_free) begin
                    n_state = bba_pkg::S_IDLE;
                end
            end
            default: n_state = bba_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bba_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_in_ready        = 1'b0;
        o_ctrl.op         = bba_pkg::OP_HOLD;
        o_ctrl.map_set    = 1'b0;
        o_ctrl.map_clr    = 1'b0;
        o_ctrl.out_load   = 1'b0;
        o_ctrl.use_q      = 1'b0;
        o_ctrl.out_status = bba_pkg::ST_OK;
        unique case (r_state)
            bba_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.op = (i_in_kind == bba_pkg::KIND_FREE) ? bba_pkg::OP_OFFSET
                                                                  : bba_pkg::OP_LOAD_BASE;
                end
            end
            bba_pkg::S_SCAN: begin
                if (i_flags.scan_end) begin
                    o_ctrl.out_status = bba_pkg::ST_FULL;
                    o_ctrl.out_load   = i_out_free;
                end else if (!i_bit_used) begin
                    o_ctrl.out_load = i_out_free;
                    o_ctrl.map_set  = i_out_free;
                end else begin
                    o_ctrl.op = bba_pkg::OP_ADD_SIZE;
                end
            end
            bba_pkg::S_DIV: begin
                o_ctrl.op = bba_pkg::OP_DIV;
            end
            bba_pkg::S_CHECK: begin
                o_ctrl.op       = bba_pkg::OP_CMP_N;
                o_ctrl.use_q    = 1'b1;
                o_ctrl.out_load = i_out_free;
                if (i_flags.q_ge_n) begin
                    o_ctrl.out_status = bba_pkg::ST_RANGE;
                end else if (i_bit_used) begin
                    o_ctrl.map_clr = i_out_free;
                end else begin
                    o_ctrl.out_status = bba_pkg::ST_NOT_USED;
                end
            end
            default: begin
            end
        endcase
    end

    `ASSERT_RST(a_div_to_check, i_clk, i_rst_n,
        (r_state == bba_pkg::S_DIV && i_flags.div_last) |=> (r_state == bba_pkg::S_CHECK))

endmodule

/* rtl/bitmap_block_allocator_unit.sv */
`timescale 1ns / 1ps
// Top level of the bitmap block allocator: stream channels, config port,
// result register. Depends on bba_pkg, bba_ctrl, bba_dpath and bba_map.
//
// Usage: a request arrives on the s_axis channel; tuser is the kind (0 allocate,
// 1 free) and tdata the address to free. Each request gives exactly one result
// transfer on m_axis holding status, block address and block index.
// Allocate scans the used map one block per cycle from block 0 and stops at the
// lowest free block, or with status full when no block of the pool is free.
// Free runs in order: the offset is formed at the accepting edge, 32 steps of
// the bit-serial divider share the single 32-bit adder, and a check state does
// the range check, the map update and the result register load.
// One request is in work at a time; s_axis_tready is high only while idle, so
// the next request is taken in the cycle after a result loads at the earliest.
// A finished result sits in the output register while the next request runs; a
// request that finishes while that register is still full holds until
// m_axis_tready takes the older result. Reset clears the used map (all blocks
// free) and sets base 0, block size 1 and block count 64. The user must write
// configuration only while no request is in work; the block does not check it.
module bitmap_block_allocator_unit #(
    parameter int BLOCKS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bba_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // free_address [31:0]
    input  logic [bba_pkg::ADDR_W-1:0]      s_axis_tdata,
    // kind [0]
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // status [1:0], block_address [33:2], block_index [39:34]
    output logic [bba_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    localparam int IW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;

    bba_pkg::t_ctrl                 w_ctrl;
    bba_pkg::t_flags                w_flags;
    logic [IW-1:0]                  w_map_idx;
    logic                           w_bit_used;
    logic [bba_pkg::ADDR_W-1:0]     w_res_addr;
    logic [bba_pkg::IDX_OUT_W-1:0]  w_res_idx;
    logic                           w_out_free;

    logic                           r_m_valid;
    bba_pkg::t_status               r_status;
    logic [bba_pkg::ADDR_W-1:0]     r_addr;
    logic [bba_pkg::IDX_OUT_W-1:0]  r_index;

    assign w_out_free = !r_m_valid || m_axis_tready;

    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_kind  (s_axis_tuser),
        .i_out_free (w_out_free),
        .i_bit_used (w_bit_used),
        .i_flags    (w_flags),
        .o_in_ready (s_axis_tready),
        .o_ctrl     (w_ctrl)
    );

    bba_dpath #(
        .BLOCKS (BLOCKS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_free_addr (s_axis_tdata),
        .i_ctrl      (w_ctrl),
        .o_flags     (w_flags),
        .o_map_idx   (w_map_idx),
        .o_res_addr  (w_res_addr),
        .o_res_idx   (w_res_idx)
    );

    bba_map #(
        .BLOCKS (BLOCKS)
    ) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_idx   (w_map_idx),
        .i_set   (w_ctrl.map_set),
        .i_clr   (w_ctrl.map_clr),
        .o_used  (w_bit_used)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_ctrl.out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.out_load) begin
            r_status <= w_ctrl.out_status;
            r_addr   <= w_res_addr;
            r_index  <= w_res_idx;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_index, r_addr, r_status};

    `ASSERT_RST(a_busy_after_accept, i_clk, i_rst_n,
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    `ASSERT_RST(a_addr_only_ok, i_clk, i_rst_n,
        (r_m_valid && r_status != bba_pkg::ST_OK) |-> (r_addr == '0))

endmodule

/* tb/bitmap_block_allocator_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of bitmap_block_allocator_unit: directed and random
// allocate/free traffic checked against a local model. Depends on bba_pkg.
module bitmap_block_allocator_unit_tb;

    localparam int   POOL_MAX     = 64;
    localparam logic KIND_ALLOC   = 1'b0;
    localparam int   RANDOM_ITEMS = 1150;

    typedef struct packed {
        bba_pkg::t_status           status;
        logic [bba_pkg::ADDR_W-1:0] addr;
        logic [5:0]                 idx;
    } t_answer;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [bba_pkg::CFG_IDX_W-1:0]    i_cfg_idx = '0;
    logic [bba_pkg::CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [bba_pkg::ADDR_W-1:0]       s_axis_tdata = '0;
    logic                             s_axis_tuser = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [bba_pkg::OUT_DATA_W-1:0]   m_axis_tdata;

    // Local copy of the allocator state and its configuration.
    logic [POOL_MAX-1:0]              used_blocks = '0;
    logic [bba_pkg::ADDR_W-1:0]       pool_base = '0;
    logic [bba_pkg::SIZE_W-1:0]       pool_size = 16'd1;
    logic [bba_pkg::COUNT_W-1:0]      pool_count = 7'd64;

    t_answer                          pending_answers[$];
    int                               mismatch_count = 0;
    int                               burst_left = 0;
    int                               alloc_sent = 0;
    int                               free_sent = 0;
    int                               pool_settings = 0;
    int                               status_seen[4] = '{0, 0, 0, 0};
    int                               rx_cycle = 0;
    int                               rx_mode = 0;

    bitmap_block_allocator_unit #(.BLOCKS(POOL_MAX)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pool_blocks();
        return (pool_count > POOL_MAX) ? POOL_MAX : int'(pool_count);
    endfunction

    function automatic logic [bba_pkg::ADDR_W-1:0] stride();
        return (pool_size == '0) ? 32'd1 : 32'(pool_size);
    endfunction

    function automatic t_answer apply_request(input logic kind,
                                              input logic [bba_pkg::ADDR_W-1:0] addr);
        t_answer                    ans;
        logic [bba_pkg::ADDR_W-1:0] offset;
        logic [bba_pkg::ADDR_W-1:0] quot;
        int                         n;
        bit                         found;
        n = pool_blocks();
        ans = '{bba_pkg::ST_FULL, 32'd0, 6'd0};
        found = 1'b0;
        if (kind == KIND_ALLOC) begin
            for (int i = 0; i < n; i++) begin
                if (!found && !used_blocks[i]) begin
                    found = 1'b1;
                    used_blocks[i] = 1'b1;
                    ans.status = bba_pkg::ST_OK;
                    ans.idx = i[5:0];
                    ans.addr = pool_base + 32'(i) * stride();
                end
            end
        end else begin
            offset = addr - pool_base;
            quot = offset / stride();
            if (quot >= 32'(n)) begin
                ans.status = bba_pkg::ST_RANGE;
            end else begin
                ans.idx = quot[5:0];
                if (used_blocks[quot[5:0]]) begin
                    used_blocks[quot[5:0]] = 1'b0;
                    ans.status = bba_pkg::ST_OK;
                end else begin
                    ans.status = bba_pkg::ST_NOT_USED;
                end
            end
        end
        return ans;
    endfunction

    function automatic int pick_used_block();
        int held[$];
        int n;
        n = pool_blocks();
        for (int i = 0; i < n; i++) begin
            if (used_blocks[i]) held.push_back(i);
        end
        if (held.size() == 0) return -1;
        return held[$urandom_range(0, held.size() - 1)];
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 100) $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic issue_request(input logic kind, input logic [bba_pkg::ADDR_W-1:0] addr);
        int      gap;
        t_answer ans;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= addr;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        ans = apply_request(kind, addr);
        pending_answers.push_back(ans);
        status_seen[ans.status]++;
        if (kind == KIND_ALLOC) alloc_sent++;
        else free_sent++;
        burst_left--;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_pool(input logic [bba_pkg::ADDR_W-1:0] base,
                            input logic [bba_pkg::SIZE_W-1:0] size,
                            input logic [bba_pkg::COUNT_W-1:0] count);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= bba_pkg::CFG_BASE;
        i_cfg_data <= base;
        @(posedge i_clk);
        i_cfg_idx  <= bba_pkg::CFG_SIZE;
        i_cfg_data <= {16'($urandom()), size};
        @(posedge i_clk);
        i_cfg_idx  <= bba_pkg::CFG_COUNT;
        i_cfg_data <= {25'($urandom()), count};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        pool_base  = base;
        pool_size  = size;
        pool_count = count;
        pool_settings++;
    endtask

    task automatic test_default_pool();
        repeat (3) issue_request(KIND_ALLOC, $urandom());
        issue_request(bba_pkg::KIND_FREE, 32'd1);
        issue_request(bba_pkg::KIND_FREE, 32'd1);
        issue_request(bba_pkg::KIND_FREE, 32'd64);
        issue_request(bba_pkg::KIND_FREE, 32'hFFFF_FFFF);
        issue_request(KIND_ALLOC, 32'hFFFF_FFFF);
        wait_idle();
    endtask

    task automatic test_wrapped_pool();
        set_pool(32'hFFFF_FFE0, 16'd16, 7'd127);
        issue_request(KIND_ALLOC, 32'd0);
        issue_request(bba_pkg::KIND_FREE, pool_base + 32'd55);
        issue_request(bba_pkg::KIND_FREE, pool_base - 32'd1);
        issue_request(bba_pkg::KIND_FREE, pool_base + 32'd1024);
        issue_request(bba_pkg::KIND_FREE, pool_base);
        wait_idle();
    endtask

    task automatic test_degenerate_pools();
        set_pool(32'h89AB_CDEF, 16'd0, 7'd2);
        issue_request(KIND_ALLOC, 32'd0);
        issue_request(KIND_ALLOC, 32'd0);
        issue_request(bba_pkg::KIND_FREE, pool_base + 32'd1);
        issue_request(bba_pkg::KIND_FREE, pool_base + 32'd2);
        wait_idle();
        set_pool(32'd0, 16'hFFFF, 7'd0);
        issue_request(KIND_ALLOC, 32'd0);
        issue_request(bba_pkg::KIND_FREE, 32'd0);
        wait_idle();
        set_pool(32'd0, 16'hFFFF, 7'd1);
        issue_request(bba_pkg::KIND_FREE, 32'h0000_FFFE);
        issue_request(KIND_ALLOC, 32'd0);
        issue_request(bba_pkg::KIND_FREE, 32'h0000_FFFF);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int                          random_sent;
        int                          phase;
        int                          phase_items;
        int                          alloc_pct;
        int                          blk;
        int                          n;
        logic [bba_pkg::ADDR_W-1:0]  base;
        logic [bba_pkg::SIZE_W-1:0]  size;
        logic [bba_pkg::COUNT_W-1:0] count;
        logic [bba_pkg::ADDR_W-1:0]  addr;
        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case (phase)
                0: begin base = 32'd0; size = 16'd1; count = 7'd64; end
                1: begin base = 32'hFFFF_FFFF; size = 16'hFFFF; count = 7'd127; end
                2: begin base = $urandom(); size = 16'd0; count = 7'd1; end
                3: begin base = 32'hFFFF_F000; size = 16'd64; count = 7'd64; end
                4: begin base = $urandom(); size = 16'd1; count = 7'd0; end
                default: begin
                    case ($urandom_range(0, 3))
                        0: base = 32'd0;
                        1: base = 32'hFFFF_FFFF - 32'($urandom_range(0, 4096));
                        default: base = $urandom();
                    endcase
                    case ($urandom_range(0, 4))
                        0: size = 16'd0;
                        1: size = 16'd1;
                        2: size = 16'hFFFF;
                        3: size = 16'($urandom_range(1, 16));
                        default: size = 16'($urandom_range(1, 65535));
                    endcase
                    case ($urandom_range(0, 9))
                        0: count = 7'd0;
                        1, 2: count = 7'($urandom_range(1, 8));
                        3, 4: count = 7'd64;
                        5: count = 7'($urandom_range(65, 127));
                        default: count = 7'($urandom_range(1, 64));
                    endcase
                end
            endcase
            set_pool(base, size, count);
            case ($urandom_range(0, 2))
                0: alloc_pct = 25;
                1: alloc_pct = 50;
                default: alloc_pct = 75;
            endcase
            phase_items = $urandom_range(40, 120);
            n = pool_blocks();
            for (int k = 0; k < phase_items && random_sent < RANDOM_ITEMS; k++) begin
                if ($urandom_range(0, 99) < alloc_pct) begin
                    issue_request(KIND_ALLOC, $urandom());
                end else begin
                    blk = pick_used_block();
                    if ($urandom_range(0, 9) < 7 && blk >= 0) begin
                        addr = pool_base + 32'(blk) * stride()
                               + 32'($urandom_range(0, stride() - 1));
                    end else begin
                        case ($urandom_range(0, 3))
                            0: addr = $urandom();
                            1: addr = pool_base + 32'(n) * stride()
                                      + 32'($urandom_range(0, 3 * stride()));
                            2: addr = pool_base - 32'($urandom_range(1, 16));
                            default: addr = pool_base + 32'($urandom_range(0, 63)) * stride();
                        endcase
                    end
                    issue_request(bba_pkg::KIND_FREE, addr);
                end
                random_sent++;
            end
            wait_idle();
            phase++;
        end
    endtask

    always @(posedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 200 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= (rx_cycle % 8 == 0);
            default: m_axis_tready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = bba_pkg::t_status'(m_axis_tdata[1:0]);
            got.addr   = m_axis_tdata[33:2];
            got.idx    = m_axis_tdata[39:34];
            if (pending_answers.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: %s addr %h idx %0d",
                                          got.status.name(), got.addr, got.idx));
            end else begin
                want = pending_answers.pop_front();
                if (got.status != want.status)
                    report_mismatch($sformatf("status %s, want %s",
                                              got.status.name(), want.status.name()));
                if (got.addr != want.addr)
                    report_mismatch($sformatf("block address %h, want %h", got.addr, want.addr));
                if (got.idx != want.idx)
                    report_mismatch($sformatf("block index %0d, want %0d", got.idx, want.idx));
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_pool();
        test_wrapped_pool();
        test_degenerate_pools();
        test_random_traffic();
        wait_idle();
        repeat (70) @(posedge i_clk);
        $display("Covered %0d allocate and %0d free transfers over %0d pool settings.",
                 alloc_sent, free_sent, pool_settings);
        $display("Results: ok %0d, full %0d, out of range %0d, not allocated %0d.",
                 status_seen[bba_pkg::ST_OK], status_seen[bba_pkg::ST_FULL],
                 status_seen[bba_pkg::ST_RANGE], status_seen[bba_pkg::ST_NOT_USED]);
        if (mismatch_count == 0 && pending_answers.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding.", pending_answers.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
